[hw/rtl/double_ended_queue_assert.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_assert.svh
// Assertion macros used by the deque top level.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Plain check on clk, masked during reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also evaluated while reset is held.
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Beat types and operation / status codes of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] data;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;
  } deq_out_t;

endpackage

[hw/rtl/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit words in a circular buffer of DEPTH
// slots held in one RAM. Front and rear words are cached in registers, so
// pushes, clear, rejected operations and pops that empty the queue finish
// without a slot read. A pop that leaves entries behind must then refill
// the new front or rear word from the slot RAM, whose read is registered,
// and no new beat is taken while that read is outstanding. A one-entry
// skid stage behind the output register lets the next beat be taken while
// a result waits to be drained. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque top level: pointer control, front/rear cache, slot RAM, output skid.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_in_t  in_payload,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_out_t out_payload
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
  endfunction

  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : AW'(i - 1'b1);
  endfunction

  logic [AW-1:0]            head_r, head_nxt;
  logic [AW-1:0]            tail_r, tail_nxt;
  logic [CW-1:0]            occ_r, occ_nxt;
  logic signed [DATA_W-1:0] front_r, front_nxt;
  logic signed [DATA_W-1:0] rear_r, rear_nxt;
  logic                     pend_r, pend_nxt;
  logic                     pfront_r, pfront_nxt;
  logic                     out_valid_r, hold_vld_r;
  deq_out_t                 out_r, hold_r;

  logic                     acc;
  logic                     out_free;
  logic                     new_vld;
  deq_out_t                 new_res;
  logic [STATUS_W-1:0]      status;
  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [DATA_W-1:0]        rdata;

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_payload.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = pend_r || hold_vld_r;
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    pend_nxt   = 1'b0;
    pfront_nxt = pfront_r;
    we         = 1'b0;
    waddr      = tail_r;
    raddr      = head_r;
    status     = ST_OK;
    new_vld    = 1'b0;

    if (pend_r) begin
      // refill the cached end from the slot read issued last cycle
      new_vld = 1'b1;
      if (pfront_r) begin
        front_nxt = rdata;
      end else begin
        rear_nxt = rdata;
      end
    end else if (acc) begin
      new_vld = 1'b1;
      unique case (in_payload.mode)
        MODE_PUSH_FRONT: begin
          if (occ_r == CW'(DEPTH)) begin
            status = ST_OVERFLOW;
          end else begin
            head_nxt  = step_back(head_r);
            we        = 1'b1;
            waddr     = step_back(head_r);
            occ_nxt   = CW'(occ_r + 1'b1);
            front_nxt = in_payload.data;
            if (occ_r == '0) begin
              rear_nxt = in_payload.data;
            end
          end
        end
        MODE_PUSH_REAR: begin
          if (occ_r == CW'(DEPTH)) begin
            status = ST_OVERFLOW;
          end else begin
            tail_nxt = step_fwd(tail_r);
            we       = 1'b1;
            waddr    = tail_r;
            occ_nxt  = CW'(occ_r + 1'b1);
            rear_nxt = in_payload.data;
            if (occ_r == '0) begin
              front_nxt = in_payload.data;
            end
          end
        end
        MODE_POP_FRONT: begin
          if (occ_r == '0) begin
            status = ST_UNDERFLOW;
          end else begin
            head_nxt = step_fwd(head_r);
            occ_nxt  = CW'(occ_r - 1'b1);
            raddr    = step_fwd(head_r);
            if (occ_r != CW'(1)) begin
              pend_nxt   = 1'b1;
              pfront_nxt = 1'b1;
              new_vld    = 1'b0;
            end
          end
        end
        MODE_POP_REAR: begin
          if (occ_r == '0) begin
            status = ST_UNDERFLOW;
          end else begin
            tail_nxt = step_back(tail_r);
            occ_nxt  = CW'(occ_r - 1'b1);
            raddr    = step_back(step_back(tail_r));
            if (occ_r != CW'(1)) begin
              pend_nxt   = 1'b1;
              pfront_nxt = 1'b0;
              new_vld    = 1'b0;
            end
          end
        end
        MODE_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          occ_nxt  = '0;
        end
        default: begin
        end
      endcase
    end

    new_res.front_value = (occ_nxt == '0) ? '1 : front_nxt;
    new_res.rear_value  = (occ_nxt == '0) ? '1 : rear_nxt;
    new_res.count       = COUNT_W'(occ_nxt);
    new_res.status      = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hold_vld_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      pend_r <= pend_nxt;
      if (out_free) begin
        out_valid_r <= hold_vld_r || new_vld;
        hold_vld_r  <= hold_vld_r && new_vld;
      end else if (new_vld) begin
        hold_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_r  <= front_nxt;
    rear_r   <= rear_nxt;
    pfront_r <= pfront_nxt;
    if (out_free) begin
      out_r  <= hold_vld_r ? hold_r : new_res;
      hold_r <= new_res;
    end else if (new_vld) begin
      hold_r <= new_res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  `DEQ_ASSERT(a_pend_one_cycle, pend_r |=> !pend_r, "slot read outstanding for more than one cycle")
  `DEQ_ASSERT(a_skid_behind_out, hold_vld_r |-> out_valid_r, "skid beat held with output empty")
  `DEQ_ASSERT(a_occ_bound, occ_r <= CW'(DEPTH), "occupancy exceeds depth")
  `DEQ_ASSERT(a_clear_empties, (acc && in_payload.mode == MODE_CLEAR) |=> (occ_r == '0 && head_r == '0 && tail_r == '0), "clear left entries behind")

endmodule
